>>> hdl/chip8_instruction_execute_core_assert.svh
// ----------------------------------------------------------------------------
// CHIP-8 execute core assertion macros
// Shared assertion forms for the checker of the instruction execute core.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define CHIP8_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

// Same-cycle implication, switched off while the reset expression is high.
`define C8X_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("c8x assertion failed");

// Next-cycle implication, switched off while the reset expression is high.
`define C8X_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("c8x assertion failed");

`endif

>>> hdl/c8x_pkg.sv
// ----------------------------------------------------------------------------
// CHIP-8 execute package
// Opcode codes, sub-codes and the structures passed between the execute
// logic and the top level.
// ----------------------------------------------------------------------------
package c8x_pkg;

   // Default depth of the return stack.
   localparam int STACK_DEPTH_DEFAULT = 16;

   // Program counter value after reset.
   localparam logic [11:0] START_ADDRESS_RESET = 12'd512;

   // Whole-word system instructions.
   localparam logic [15:0] WORD_HALT = 16'h0000;
   localparam logic [15:0] WORD_CLS  = 16'h00E0;
   localparam logic [15:0] WORD_RET  = 16'h00EE;

   // Index of the flag register.
   localparam logic [3:0] FLAG_REG = 4'hF;

   // Top nibble of the instruction word.
   typedef enum logic [3:0] {
      OP_SYS     = 4'h0,
      OP_JP      = 4'h1,
      OP_CALL    = 4'h2,
      OP_SE_IMM  = 4'h3,
      OP_SNE_IMM = 4'h4,
      OP_SE_REG  = 4'h5,
      OP_LD_IMM  = 4'h6,
      OP_ADD_IMM = 4'h7,
      OP_ALU     = 4'h8,
      OP_SNE_REG = 4'h9,
      OP_LD_I    = 4'hA,
      OP_JP_V0   = 4'hB,
      OP_RND     = 4'hC,
      OP_DRW     = 4'hD,
      OP_SKP     = 4'hE,
      OP_MISC    = 4'hF
   } opcode_type;

   // Low nibble of the register-register ALU group.
   localparam logic [3:0] ALU_LD   = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   // Low byte of the miscellaneous group.
   localparam logic [7:0] MISC_LD_VX_DT = 8'h07;
   localparam logic [7:0] MISC_LD_DT_VX = 8'h15;
   localparam logic [7:0] MISC_LD_ST_VX = 8'h18;
   localparam logic [7:0] MISC_ADD_I_VX = 8'h1E;

   // Everything the execute logic decides for one instruction.
   typedef struct packed {
      logic        vx_we;
      logic [7:0]  vx_data;
      logic        vf_we;
      logic        vf_flag;
      logic        push;
      logic        pop;
      logic [11:0] push_pc;
      logic [11:0] pc;
      logic [15:0] index;
      logic [7:0]  delay;
      logic [7:0]  sound;
      logic        halted;
      logic        clear_screen;
      logic        draw_request;
      logic [3:0]  draw_x_reg;
      logic [3:0]  draw_y_reg;
      logic [3:0]  draw_rows;
      logic        unsupported;
   } exec_type;

   // One result beat.
   typedef struct packed {
      logic [11:0] next_pc;
      logic [15:0] index_value;
      logic        halted;
      logic        clear_screen;
      logic        draw_request;
      logic [3:0]  draw_x_reg;
      logic [3:0]  draw_y_reg;
      logic [3:0]  draw_rows;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
      logic        unsupported;
   } rsp_type;

endpackage

>>> hdl/c8x_exec.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction decode and execute
// Combinational decode of one instruction word against the current
// architectural state, giving the state updates and the result flags.
// ----------------------------------------------------------------------------
module c8x_exec
   import c8x_pkg::*;
(
   input  logic [15:0] instr,
   input  logic [7:0]  rnd,
   input  logic [7:0]  vx,
   input  logic [7:0]  vy,
   input  logic [7:0]  v0,
   input  logic [11:0] pc,
   input  logic [15:0] index,
   input  logic [7:0]  delay,
   input  logic [7:0]  sound,
   input  logic [11:0] stack_top,
   output exec_type    exec
);

   logic [3:0]  op_nib;
   logic [3:0]  y_idx;
   logic [3:0]  n_nib;
   logic [3:0]  x_idx;
   logic [7:0]  kk;
   logic [11:0] nnn;
   logic [11:0] pc_plus2;
   logic [11:0] pc_plus4;
   logic [8:0]  sum;

   // Instruction fields.
   assign op_nib   = instr[15:12];
   assign x_idx    = instr[11:8];
   assign y_idx    = instr[7:4];
   assign n_nib    = instr[3:0];
   assign kk       = instr[7:0];
   assign nnn      = instr[11:0];
   assign pc_plus2 = pc + 12'd2;
   assign pc_plus4 = pc + 12'd4;
   assign sum      = {1'b0, vx} + {1'b0, vy};

   // Decode and execute. By default the PC steps over the instruction and
   // all other state holds.
   always_comb begin
      exec         = '0;
      exec.pc      = pc_plus2;
      exec.push_pc = pc_plus2;
      exec.index   = index;
      exec.delay   = delay;
      exec.sound   = sound;

      if (instr == WORD_HALT) begin
         exec.halted = 1'b1;
         exec.pc     = pc;
      end else begin
         unique case (opcode_type'(op_nib))
            OP_SYS: begin
               if (instr == WORD_CLS) begin
                  exec.clear_screen = 1'b1;
               end else if (instr == WORD_RET) begin
                  exec.pop = 1'b1;
                  exec.pc  = stack_top;
               end else begin
                  exec.unsupported = 1'b1;
               end
            end
            OP_JP: begin
               exec.pc = nnn;
            end
            OP_CALL: begin
               exec.push = 1'b1;
               exec.pc   = nnn;
            end
            OP_SE_IMM: begin
               if (vx == kk) exec.pc = pc_plus4;
            end
            OP_SNE_IMM: begin
               if (vx != kk) exec.pc = pc_plus4;
            end
            OP_SE_REG: begin
               if (vx == vy) exec.pc = pc_plus4;
            end
            OP_LD_IMM: begin
               exec.vx_we   = 1'b1;
               exec.vx_data = kk;
            end
            OP_ADD_IMM: begin
               exec.vx_we   = 1'b1;
               exec.vx_data = vx + kk;
            end
            OP_ALU: begin
               unique case (n_nib)
                  ALU_LD: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vy;
                  end
                  ALU_OR: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vx | vy;
                  end
                  ALU_AND: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vx & vy;
                  end
                  ALU_XOR: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vx ^ vy;
                  end
                  ALU_ADD: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = sum[7:0];
                     exec.vf_we   = 1'b1;
                     exec.vf_flag = sum[8];
                  end
                  ALU_SUB: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vx - vy;
                     exec.vf_we   = 1'b1;
                     exec.vf_flag = (vx >= vy);
                  end
                  ALU_SHR: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = {1'b0, vx[7:1]};
                     exec.vf_we   = 1'b1;
                     exec.vf_flag = vx[0];
                  end
                  ALU_SUBN: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = vy - vx;
                     exec.vf_we   = 1'b1;
                     exec.vf_flag = (vy >= vx);
                  end
                  ALU_SHL: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = {vx[6:0], 1'b0};
                     exec.vf_we   = 1'b1;
                     exec.vf_flag = vx[7];
                  end
                  default: begin
                     exec.unsupported = 1'b1;
                  end
               endcase
            end
            OP_SNE_REG: begin
               if (vx != vy) exec.pc = pc_plus4;
            end
            OP_LD_I: begin
               exec.index = {4'b0000, nnn};
            end
            OP_JP_V0: begin
               exec.pc = nnn + {4'b0000, v0};
            end
            OP_RND: begin
               exec.vx_we   = 1'b1;
               exec.vx_data = rnd & kk;
            end
            OP_DRW: begin
               exec.draw_request = 1'b1;
               exec.draw_x_reg   = x_idx;
               exec.draw_y_reg   = y_idx;
               exec.draw_rows    = n_nib;
            end
            OP_SKP: begin
               exec.unsupported = 1'b1;
            end
            OP_MISC: begin
               unique case (kk)
                  MISC_LD_VX_DT: begin
                     exec.vx_we   = 1'b1;
                     exec.vx_data = delay;
                  end
                  MISC_LD_DT_VX: begin
                     exec.delay = vx;
                  end
                  MISC_LD_ST_VX: begin
                     exec.sound = vx;
                  end
                  MISC_ADD_I_VX: begin
                     exec.index = index + {8'h00, vx};
                  end
                  default: begin
                     exec.unsupported = 1'b1;
                  end
               endcase
            end
            default: begin
               exec.unsupported = 1'b1;
            end
         endcase
      end
   end

endmodule

>>> hdl/c8x_stack.sv
// ----------------------------------------------------------------------------
// CHIP-8 return stack
// Circular return-address stack held in a memory, with the top entry kept
// in a register and the entry below it prefetched every cycle.
// ----------------------------------------------------------------------------
module c8x_stack
   import c8x_pkg::*;
#(
   parameter int DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        pop,
   input  logic [11:0] push_data,
   output logic [11:0] top
);

   localparam int SP_W = $clog2(DEPTH);
   localparam logic [SP_W-1:0] SP_LAST = SP_W'(DEPTH - 1);

   logic [11:0]     mem [DEPTH];
   logic [SP_W-1:0] sp_ff;
   logic [SP_W-1:0] sp_in;
   logic [SP_W-1:0] rd_addr;
   logic [11:0]     rd_ff;
   logic [11:0]     top_ff;
   logic [11:0]     top_in;

   // Pointer wraps at the stack depth in both directions.
   always_comb begin
      sp_in = sp_ff;
      if (push) begin
         sp_in = (sp_ff == SP_LAST) ? '0 : sp_ff + 1'b1;
      end else if (pop) begin
         sp_in = (sp_ff == '0) ? SP_LAST : sp_ff - 1'b1;
      end
   end

   // The entry below the new top is read ahead, ready for the next return.
   assign rd_addr = (sp_in == '0) ? SP_LAST : sp_in - 1'b1;

   // Top of stack follows a call directly and a return from the prefetch.
   always_comb begin
      top_in = top_ff;
      if (push) begin
         top_in = push_data;
      end else if (pop) begin
         top_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   // Memory and cached top; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[sp_in] <= push_data;
      end
      rd_ff  <= mem[rd_addr];
      top_ff <= top_in;
   end

   assign top = top_ff;

endmodule

>>> hdl/chip8_instruction_execute_core.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute core
// Executes one CHIP-8 instruction per beat against its own register file,
// program counter, index register, timers and return stack.
// ----------------------------------------------------------------------------
// The core takes one instruction beat per clock cycle while the result side
// is ready, and returns one result beat for each. An accepted instruction
// goes into an input register, is decoded and executed against the
// architectural state, and its result lands in an output register while the
// state updates at the same edge. The result is therefore offered once it has
// passed the input register and then the output register. The input register
// takes a new beat whenever it is empty or its instruction executes in the
// same cycle. While a result waits, it holds one more instruction and then
// stops the input until the result side is ready again. Back-to-back
// instructions see the state left by their predecessor. The return stack
// lives in a memory whose top entry is cached in a register and whose next
// entry down is prefetched every cycle, so calls and returns also run at
// full rate. The configuration port drives no register: writes to it have no
// effect, and the program counter always starts at 512 after reset.
module chip8_instruction_execute_core
   import c8x_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,
   // Instruction channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_instruction_word,
   input  logic [7:0]  req_random_byte,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_next_pc,
   output logic [15:0] rsp_index_value,
   output logic        rsp_halted,
   output logic        rsp_clear_screen,
   output logic        rsp_draw_request,
   output logic [3:0]  rsp_draw_x_reg,
   output logic [3:0]  rsp_draw_y_reg,
   output logic [3:0]  rsp_draw_rows,
   output logic [7:0]  rsp_delay_value,
   output logic [7:0]  rsp_sound_value,
   output logic        rsp_unsupported
);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [15:0] instr_ff;
   logic [15:0] instr_in;
   logic [7:0]  rnd_ff;
   logic [7:0]  rnd_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;
   logic [7:0]  regs_ff [16];
   logic [7:0]  regs_in [16];
   logic [11:0] pc_ff;
   logic [11:0] pc_in;
   logic [15:0] index_ff;
   logic [15:0] index_in;
   logic [7:0]  delay_ff;
   logic [7:0]  delay_in;
   logic [7:0]  sound_ff;
   logic [7:0]  sound_in;
   logic        exec_fire;
   logic [3:0]  x_idx;
   logic [3:0]  y_idx;
   logic [11:0] stack_top;
   exec_type    exec;

   // An instruction executes when the result register is free or emptying.
   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || exec_fire;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      instr_in    = instr_ff;
      rnd_in      = rnd_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         instr_in    = req_instruction_word;
         rnd_in      = req_random_byte;
      end else if (exec_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Register file reads.
   assign x_idx = instr_ff[11:8];
   assign y_idx = instr_ff[7:4];

   c8x_exec u_exec (
      .instr     (instr_ff),
      .rnd       (rnd_ff),
      .vx        (regs_ff[x_idx]),
      .vy        (regs_ff[y_idx]),
      .v0        (regs_ff[0]),
      .pc        (pc_ff),
      .index     (index_ff),
      .delay     (delay_ff),
      .sound     (sound_ff),
      .stack_top (stack_top),
      .exec      (exec)
   );

   c8x_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock     (clock),
      .reset     (reset),
      .push      (exec_fire && exec.push),
      .pop       (exec_fire && exec.pop),
      .push_data (exec.push_pc),
      .top       (stack_top)
   );

   // Architectural state update; the flag write comes last so it wins on VF.
   always_comb begin
      regs_in  = regs_ff;
      pc_in    = pc_ff;
      index_in = index_ff;
      delay_in = delay_ff;
      sound_in = sound_ff;
      if (exec_fire) begin
         pc_in    = exec.pc;
         index_in = exec.index;
         delay_in = exec.delay;
         sound_in = exec.sound;
         if (exec.vx_we) begin
            regs_in[x_idx] = exec.vx_data;
         end
         if (exec.vf_we) begin
            regs_in[FLAG_REG] = {7'b0000000, exec.vf_flag};
         end
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (exec_fire) begin
         rsp_valid_in        = 1'b1;
         rsp_in.next_pc      = exec.pc;
         rsp_in.index_value  = exec.index;
         rsp_in.halted       = exec.halted;
         rsp_in.clear_screen = exec.clear_screen;
         rsp_in.draw_request = exec.draw_request;
         rsp_in.draw_x_reg   = exec.draw_x_reg;
         rsp_in.draw_y_reg   = exec.draw_y_reg;
         rsp_in.draw_rows    = exec.draw_rows;
         rsp_in.delay_value  = exec.delay;
         rsp_in.sound_value  = exec.sound;
         rsp_in.unsupported  = exec.unsupported;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         regs_ff      <= '{default: 8'h00};
         pc_ff        <= START_ADDRESS_RESET;
         index_ff     <= '0;
         delay_ff     <= '0;
         sound_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
         pc_ff        <= pc_in;
         index_ff     <= index_in;
         delay_ff     <= delay_in;
         sound_ff     <= sound_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      instr_ff <= instr_in;
      rnd_ff   <= rnd_in;
      rsp_ff   <= rsp_in;
   end

   // Result outputs.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_ff.next_pc;
   assign rsp_index_value  = rsp_ff.index_value;
   assign rsp_halted       = rsp_ff.halted;
   assign rsp_clear_screen = rsp_ff.clear_screen;
   assign rsp_draw_request = rsp_ff.draw_request;
   assign rsp_draw_x_reg   = rsp_ff.draw_x_reg;
   assign rsp_draw_y_reg   = rsp_ff.draw_y_reg;
   assign rsp_draw_rows    = rsp_ff.draw_rows;
   assign rsp_delay_value  = rsp_ff.delay_value;
   assign rsp_sound_value  = rsp_ff.sound_value;
   assign rsp_unsupported  = rsp_ff.unsupported;

endmodule

>>> hdl/c8x_checker.sv
// ----------------------------------------------------------------------------
// CHIP-8 execute core checker
// Port-level assertions for the instruction execute core, bound to the top.
// ----------------------------------------------------------------------------
`include "chip8_instruction_execute_core_assert.svh"

module c8x_checker
   import c8x_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [11:0] rsp_next_pc,
   input logic        rsp_halted,
   input logic        rsp_clear_screen,
   input logic        rsp_draw_request,
   input logic [3:0]  rsp_draw_x_reg,
   input logic [3:0]  rsp_draw_y_reg,
   input logic [3:0]  rsp_draw_rows,
   input logic        rsp_unsupported
);

   // No result beat is offered in the cycle after reset.
   `C8X_ASSERT_NEXT(a_idle_after_reset, clock, 1'b0, reset, !rsp_valid)

   // A halt beat carries no request and no unsupported flag.
   `C8X_ASSERT_IMPLIES(a_halt_quiet, clock, reset, rsp_valid && rsp_halted, !rsp_clear_screen && !rsp_draw_request && !rsp_unsupported)

   // At most one kind of outcome is reported per beat.
   `C8X_ASSERT_IMPLIES(a_one_outcome, clock, reset, rsp_valid, $onehot0({rsp_halted, rsp_clear_screen, rsp_draw_request, rsp_unsupported}))

   // Draw fields read zero unless a draw is requested.
   `C8X_ASSERT_IMPLIES(a_draw_fields, clock, reset, rsp_valid && !rsp_draw_request, rsp_draw_x_reg == 4'h0 && rsp_draw_y_reg == 4'h0 && rsp_draw_rows == 4'h0)

   // A stalled result beat holds.
   `C8X_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_next_pc))

endmodule

bind chip8_instruction_execute_core c8x_checker u_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// CHIP-8 instruction execute core testbench
// Drives instruction beats into the core and checks every result beat. An
// in-bench predictor keeps its own copy of the register file, program counter,
// index register, timers and return stack. Directed tests cover flag, wrap and
// unimplemented encodings. Long sequences cover index and stack wraparound, and
// a random program covers the rest. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import c8x_pkg::*;

   localparam int RET_DEPTH    = STACK_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 720;
   localparam int BLOCK_ITEMS  = 60;

   // Encodings that the core leaves unimplemented.
   localparam logic [3:0] ALU_RESERVED_FIRST = 4'h8;
   localparam logic [3:0] ALU_RESERVED_LAST  = 4'hD;
   localparam logic [3:0] ALU_RESERVED_TOP   = 4'hF;
   localparam logic [7:0] SKP_PRESSED        = 8'h9E;
   localparam logic [7:0] SKP_RELEASED       = 8'hA1;
   localparam logic [7:0] MISC_KEY_WAIT      = 8'h0A;
   localparam logic [7:0] MISC_FONT          = 8'h29;
   localparam logic [7:0] MISC_BCD           = 8'h33;
   localparam logic [7:0] MISC_STORE         = 8'h55;
   localparam logic [7:0] MISC_LOAD          = 8'h65;
   localparam logic [7:0] MISC_ALL_ONES      = 8'hFF;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [11:0] csr_wr_data;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_instruction_word;
   logic [7:0]  req_random_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_next_pc;
   logic [15:0] rsp_index_value;
   logic        rsp_halted;
   logic        rsp_clear_screen;
   logic        rsp_draw_request;
   logic [3:0]  rsp_draw_x_reg;
   logic [3:0]  rsp_draw_y_reg;
   logic [3:0]  rsp_draw_rows;
   logic [7:0]  rsp_delay_value;
   logic [7:0]  rsp_sound_value;
   logic        rsp_unsupported;

   // Architectural state as the predictor sees it.
   logic [7:0]  vregs [16];
   logic [11:0] prog_counter;
   logic [15:0] index_reg_q;
   logic [11:0] ret_stack [RET_DEPTH];
   bit          ret_written [RET_DEPTH];
   int unsigned ret_ptr;
   logic [7:0]  delay_timer_q;
   logic [7:0]  sound_timer_q;
   logic [11:0] start_address_q;

   rsp_type     pending_results [$];
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   bit          gaps_on;

   chip8_instruction_execute_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_instruction_word (req_instruction_word),
      .req_random_byte      (req_random_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_pc          (rsp_next_pc),
      .rsp_index_value      (rsp_index_value),
      .rsp_halted           (rsp_halted),
      .rsp_clear_screen     (rsp_clear_screen),
      .rsp_draw_request     (rsp_draw_request),
      .rsp_draw_x_reg       (rsp_draw_x_reg),
      .rsp_draw_y_reg       (rsp_draw_y_reg),
      .rsp_draw_rows        (rsp_draw_rows),
      .rsp_delay_value      (rsp_delay_value),
      .rsp_sound_value      (rsp_sound_value),
      .rsp_unsupported      (rsp_unsupported)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("chip8_instruction_execute_core test failed");
         $finish;
      end
   end

   // Instruction word builders.
   function automatic logic [15:0] reg_word(input opcode_type op, input logic [3:0] x,
                                            input logic [3:0] y, input logic [3:0] n);
      return {op, x, y, n};
   endfunction

   function automatic logic [15:0] imm_word(input opcode_type op, input logic [3:0] x,
                                            input logic [7:0] kk);
      return {op, x, kk};
   endfunction

   function automatic logic [15:0] addr_word(input opcode_type op, input logic [11:0] nnn);
      return {op, nnn};
   endfunction

   // Executes one instruction against the mirrored state and returns the
   // result beat that the core should produce for it.
   function automatic rsp_type execute_instruction(input logic [15:0] word,
                                                   input logic [7:0] rnd);
      rsp_type    res;
      logic [3:0] x;
      logic [3:0] y;
      logic [3:0] n;
      logic [7:0] kk;
      logic [11:0] nnn;
      logic [7:0] vx;
      logic [7:0] vy;
      logic [8:0] sum;
      logic       advance;
      x       = word[11:8];
      y       = word[7:4];
      n       = word[3:0];
      kk      = word[7:0];
      nnn     = word[11:0];
      vx      = vregs[x];
      vy      = vregs[y];
      res     = '0;
      advance = 1'b1;
      if (word == WORD_HALT) begin
         res.halted = 1'b1;
         advance    = 1'b0;
      end else begin
         case (opcode_type'(word[15:12]))
            OP_SYS: begin
               if (word == WORD_CLS) begin
                  res.clear_screen = 1'b1;
               end else if (word == WORD_RET) begin
                  prog_counter = ret_stack[ret_ptr];
                  ret_ptr      = (ret_ptr == 0) ? RET_DEPTH - 1 : ret_ptr - 1;
                  advance      = 1'b0;
               end else begin
                  res.unsupported = 1'b1;
               end
            end
            OP_JP: begin
               prog_counter = nnn;
               advance      = 1'b0;
            end
            OP_CALL: begin
               // Overflow wraps the pointer and overwrites the oldest entry.
               ret_ptr              = (ret_ptr + 1) % RET_DEPTH;
               ret_stack[ret_ptr]   = prog_counter + 12'd2;
               ret_written[ret_ptr] = 1'b1;
               prog_counter         = nnn;
               advance              = 1'b0;
            end
            OP_SE_IMM:  if (vx == kk) prog_counter = prog_counter + 12'd2;
            OP_SNE_IMM: if (vx != kk) prog_counter = prog_counter + 12'd2;
            OP_SE_REG:  if (vx == vy) prog_counter = prog_counter + 12'd2;
            OP_SNE_REG: if (vx != vy) prog_counter = prog_counter + 12'd2;
            OP_LD_IMM:  vregs[x] = kk;
            OP_ADD_IMM: vregs[x] = vx + kk;
            OP_ALU: begin
               // Operands are taken before the write; the flag goes last.
               case (n)
                  ALU_LD:  vregs[x] = vy;
                  ALU_OR:  vregs[x] = vx | vy;
                  ALU_AND: vregs[x] = vx & vy;
                  ALU_XOR: vregs[x] = vx ^ vy;
                  ALU_ADD: begin
                     sum             = {1'b0, vx} + {1'b0, vy};
                     vregs[x]        = sum[7:0];
                     vregs[FLAG_REG] = {7'd0, sum[8]};
                  end
                  ALU_SUB: begin
                     vregs[x]        = vx - vy;
                     vregs[FLAG_REG] = (vx >= vy) ? 8'd1 : 8'd0;
                  end
                  ALU_SHR: begin
                     vregs[x]        = vx >> 1;
                     vregs[FLAG_REG] = {7'd0, vx[0]};
                  end
                  ALU_SUBN: begin
                     vregs[x]        = vy - vx;
                     vregs[FLAG_REG] = (vy >= vx) ? 8'd1 : 8'd0;
                  end
                  ALU_SHL: begin
                     vregs[x]        = vx << 1;
                     vregs[FLAG_REG] = {7'd0, vx[7]};
                  end
                  default: res.unsupported = 1'b1;
               endcase
            end
            OP_LD_I: index_reg_q = {4'd0, nnn};
            OP_JP_V0: begin
               prog_counter = nnn + {4'd0, vregs[0]};
               advance      = 1'b0;
            end
            OP_RND: vregs[x] = rnd & kk;
            OP_DRW: begin
               res.draw_request = 1'b1;
               res.draw_x_reg   = x;
               res.draw_y_reg   = y;
               res.draw_rows    = n;
            end
            OP_SKP: res.unsupported = 1'b1;
            OP_MISC: begin
               case (kk)
                  MISC_LD_VX_DT: vregs[x] = delay_timer_q;
                  MISC_LD_DT_VX: delay_timer_q = vx;
                  MISC_LD_ST_VX: sound_timer_q = vx;
                  MISC_ADD_I_VX: index_reg_q = index_reg_q + {8'd0, vx};
                  default:       res.unsupported = 1'b1;
               endcase
            end
         endcase
      end
      if (advance) prog_counter = prog_counter + 12'd2;
      res.next_pc     = prog_counter;
      res.index_value = index_reg_q;
      res.delay_value = delay_timer_q;
      res.sound_value = sound_timer_q;
      return res;
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] expected,
                                         input logic [15:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %h, actual %h", name, expected, actual);
         fault_count++;
      end
   endfunction

   // Each result beat is checked against the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no expectation, next_pc %h", rsp_next_pc);
            fault_count++;
         end else begin
            exp_res = pending_results.pop_front();
            compare_field("next_pc", exp_res.next_pc, rsp_next_pc);
            compare_field("index_value", exp_res.index_value, rsp_index_value);
            compare_field("halted", exp_res.halted, rsp_halted);
            compare_field("clear_screen", exp_res.clear_screen, rsp_clear_screen);
            compare_field("draw_request", exp_res.draw_request, rsp_draw_request);
            compare_field("draw_x_reg", exp_res.draw_x_reg, rsp_draw_x_reg);
            compare_field("draw_y_reg", exp_res.draw_y_reg, rsp_draw_y_reg);
            compare_field("draw_rows", exp_res.draw_rows, rsp_draw_rows);
            compare_field("delay_value", exp_res.delay_value, rsp_delay_value);
            compare_field("sound_value", exp_res.sound_value, rsp_sound_value);
            compare_field("unsupported", exp_res.unsupported, rsp_unsupported);
         end
      end
   end

   // The result side draws a stall before each beat it takes.
   initial begin : result_stall
      int unsigned stall;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         stall = gaps_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Sends one instruction beat, after a random gap if gaps are on, and
   // records its outcome. Valid stays high between back-to-back beats.
   task automatic issue_instruction(input logic [15:0] word, input logic [7:0] rnd);
      int unsigned gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_instruction_word <= word;
      req_random_byte      <= rnd;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(execute_instruction(word, rnd));
   endtask

   // Lets every outstanding result arrive so that the core is idle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // The core ignores the configuration port, and the run never resets
   // again, so a write must leave the program flow untouched.
   task automatic write_start_address(input logic [11:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      start_address_q = value;
   endtask

   // Halt shows the reset state untouched; then clear screen and a stray
   // system word.
   task automatic test_system_words();
      issue_instruction(WORD_HALT, 8'h00);
      issue_instruction(WORD_CLS, 8'hFF);
      issue_instruction(addr_word(OP_SYS, 12'h123), 8'h00);
   endtask

   // Register values become visible through the timers.
   task automatic test_alu_flags();
      issue_instruction(imm_word(OP_LD_IMM, 4'h1, 8'hFF), 8'h00);
      issue_instruction(imm_word(OP_LD_IMM, 4'h2, 8'h02), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h1, 4'h2, ALU_ADD), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h1, MISC_LD_DT_VX), 8'h00);
      issue_instruction(imm_word(OP_MISC, FLAG_REG, MISC_LD_ST_VX), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h1, 4'h2, ALU_SUB), 8'h00);
      issue_instruction(imm_word(OP_MISC, FLAG_REG, MISC_LD_ST_VX), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h2, 4'h1, ALU_SUBN), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h3, 4'h1, ALU_LD), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h3, 4'h2, ALU_OR), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h3, 4'h2, ALU_AND), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h3, 4'h1, ALU_XOR), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h3, MISC_LD_DT_VX), 8'h00);
      // With X as the flag register the flag overwrites the shifted value.
      issue_instruction(imm_word(OP_LD_IMM, FLAG_REG, 8'h81), 8'h00);
      issue_instruction(reg_word(OP_ALU, FLAG_REG, FLAG_REG, ALU_SHL), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h2, 4'h0, ALU_SHR), 8'h00);
      issue_instruction(imm_word(OP_MISC, FLAG_REG, MISC_LD_ST_VX), 8'h00);
   endtask

   // Jumps, skips, call, return and draw around the top of the address space.
   task automatic test_control_flow();
      issue_instruction(addr_word(OP_JP, 12'hFFE), 8'h00);
      issue_instruction(imm_word(OP_SE_IMM, 4'h0, 8'h00), 8'h00);
      issue_instruction(addr_word(OP_JP, 12'hFFE), 8'h00);
      issue_instruction(addr_word(OP_CALL, 12'h345), 8'h00);
      issue_instruction(WORD_RET, 8'h00);
      issue_instruction(reg_word(OP_SE_REG, 4'h1, 4'h1, 4'hF), 8'h00);
      issue_instruction(reg_word(OP_SNE_REG, 4'h1, 4'h2, 4'h7), 8'h00);
      issue_instruction(imm_word(OP_SNE_IMM, 4'h4, 8'h00), 8'h00);
      issue_instruction(imm_word(OP_LD_IMM, 4'h0, 8'h05), 8'h00);
      issue_instruction(addr_word(OP_JP_V0, 12'hFFF), 8'h00);
      issue_instruction(reg_word(OP_DRW, 4'hA, 4'hB, 4'hF), 8'h00);
   endtask

   task automatic test_timers_and_index();
      issue_instruction(addr_word(OP_LD_I, 12'hFFF), 8'h00);
      issue_instruction(imm_word(OP_LD_IMM, 4'hA, 8'hFE), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hA, MISC_ADD_I_VX), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hA, MISC_LD_DT_VX), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hA, MISC_LD_ST_VX), 8'h00);
      issue_instruction(imm_word(OP_RND, 4'h3, 8'hA5), 8'hFF);
      issue_instruction(imm_word(OP_MISC, 4'h3, MISC_LD_DT_VX), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hB, MISC_LD_VX_DT), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hB, MISC_LD_ST_VX), 8'h00);
      issue_instruction(imm_word(OP_RND, 4'h3, 8'hFF), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h3, MISC_LD_DT_VX), 8'h00);
   endtask

   task automatic test_unsupported_words();
      issue_instruction(reg_word(OP_ALU, 4'h0, 4'h1, ALU_RESERVED_FIRST), 8'h00);
      issue_instruction(reg_word(OP_ALU, 4'h2, 4'h3, ALU_RESERVED_TOP), 8'h00);
      issue_instruction(imm_word(OP_SKP, 4'h1, SKP_PRESSED), 8'h00);
      issue_instruction(imm_word(OP_SKP, 4'h2, SKP_RELEASED), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h0, MISC_KEY_WAIT), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h1, MISC_FONT), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h2, MISC_BCD), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h3, MISC_STORE), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'h4, MISC_LOAD), 8'h00);
      issue_instruction(imm_word(OP_MISC, 4'hF, MISC_ALL_ONES), 8'hFF);
   endtask

   // Adds large register values to the index until it wraps past 16 bits.
   task automatic test_index_wraparound();
      logic [15:0] prev;
      int          steps;
      for (int r = 0; r < 3; r++) begin
         issue_instruction(imm_word(OP_LD_IMM, 4'(r), 8'($urandom_range(8'hC0, 8'hFF))),
                           8'($urandom));
      end
      issue_instruction(addr_word(OP_LD_I, 12'($urandom)), 8'($urandom));
      steps = 0;
      do begin
         prev = index_reg_q;
         issue_instruction(imm_word(OP_MISC, 4'($urandom_range(0, 2)), MISC_ADD_I_VX),
                           8'($urandom));
         steps++;
      end while (index_reg_q >= prev && steps < 400);
      issue_instruction(imm_word(OP_MISC, 4'h0, MISC_ADD_I_VX), 8'($urandom));
   endtask

   // A call chain deeper than the stack, then returns past the bottom.
   task automatic test_stack_wraparound();
      for (int c = 0; c < RET_DEPTH + 2; c++) begin
         issue_instruction(addr_word(OP_CALL, 12'($urandom)), 8'($urandom));
      end
      for (int c = 0; c < RET_DEPTH + 4; c++) begin
         issue_instruction(WORD_RET, 8'($urandom));
      end
   endtask

   // Picks one instruction with the current state in view: skips often
   // compare against the live register value, and a return is only issued
   // when its stack entry holds a return address.
   function automatic logic [15:0] pick_instruction();
      logic [3:0]  x;
      logic [3:0]  y;
      logic [3:0]  sub;
      logic [7:0]  kk;
      logic [7:0]  code;
      logic [15:0] word;
      int unsigned sel;
      x    = 4'($urandom);
      y    = 4'($urandom);
      kk   = 8'($urandom);
      sel  = $urandom_range(0, 99);
      word = WORD_CLS;
      if (sel < 6) begin
         if ($urandom_range(0, 1) != 0) kk = vregs[x];
         word = imm_word(($urandom_range(0, 1) != 0) ? OP_SE_IMM : OP_SNE_IMM, x, kk);
      end else if (sel < 11) begin
         if ($urandom_range(0, 2) == 0) y = x;
         word = reg_word(($urandom_range(0, 1) != 0) ? OP_SE_REG : OP_SNE_REG, x, y,
                         4'($urandom));
      end else if (sel < 21) begin
         if ($urandom_range(0, 3) == 0) kk = vregs[y];
         word = imm_word(OP_LD_IMM, x, kk);
      end else if (sel < 27) begin
         word = imm_word(OP_ADD_IMM, x, kk);
      end else if (sel < 46) begin
         case ($urandom_range(0, 9))
            0:       sub = ALU_LD;
            1:       sub = ALU_OR;
            2:       sub = ALU_AND;
            3:       sub = ALU_XOR;
            4:       sub = ALU_ADD;
            5:       sub = ALU_SUB;
            6:       sub = ALU_SHR;
            7:       sub = ALU_SUBN;
            8:       sub = ALU_SHL;
            default: sub = ($urandom_range(0, 6) == 0) ? ALU_RESERVED_TOP :
                           4'($urandom_range(ALU_RESERVED_FIRST, ALU_RESERVED_LAST));
         endcase
         word = reg_word(OP_ALU, x, y, sub);
      end else if (sel < 50) begin
         word = addr_word(OP_LD_I, 12'($urandom));
      end else if (sel < 54) begin
         word = imm_word(OP_RND, x, kk);
      end else if (sel < 58) begin
         word = reg_word(OP_DRW, x, y, 4'($urandom));
      end else if (sel < 66) begin
         word = addr_word(OP_CALL, 12'($urandom));
      end else if (sel < 75) begin
         word = WORD_RET;
      end else if (sel < 79) begin
         word = addr_word(OP_JP, 12'($urandom));
      end else if (sel < 82) begin
         word = addr_word(OP_JP_V0, 12'($urandom));
      end else if (sel < 90) begin
         case ($urandom_range(0, 3))
            0:       code = MISC_LD_VX_DT;
            1:       code = MISC_LD_DT_VX;
            2:       code = MISC_LD_ST_VX;
            default: code = MISC_ADD_I_VX;
         endcase
         word = imm_word(OP_MISC, x, code);
      end else if (sel < 92) begin
         case ($urandom_range(0, 5))
            0:       code = MISC_KEY_WAIT;
            1:       code = MISC_FONT;
            2:       code = MISC_BCD;
            3:       code = MISC_STORE;
            4:       code = MISC_LOAD;
            default: code = kk;
         endcase
         word = imm_word(OP_MISC, x, code);
      end else if (sel < 93) begin
         word = imm_word(OP_SKP, x, kk);
      end else if (sel < 94) begin
         word = WORD_CLS;
      end else if (sel < 95) begin
         word = WORD_HALT;
      end else if (sel < 96) begin
         word = addr_word(OP_SYS, 12'($urandom));
      end else begin
         word = 16'($urandom);
      end
      if (word == WORD_RET && !ret_written[ret_ptr]) word = WORD_CLS;
      return word;
   endfunction

   // Random program in blocks, some of them without any idling.
   task automatic test_random_program();
      for (int b = 0; b < RANDOM_ITEMS / BLOCK_ITEMS; b++) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < BLOCK_ITEMS; i++) begin
            issue_instruction(pick_instruction(), 8'($urandom));
         end
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_valid            = 1'b0;
      req_instruction_word = '0;
      req_random_byte      = '0;
      gaps_on              = 1'b1;
      for (int r = 0; r < 16; r++) vregs[r] = '0;
      for (int s = 0; s < RET_DEPTH; s++) begin
         ret_stack[s]   = '0;
         ret_written[s] = 1'b0;
      end
      ret_ptr         = 0;
      start_address_q = START_ADDRESS_RESET;
      prog_counter    = START_ADDRESS_RESET;
      index_reg_q     = '0;
      delay_timer_q   = '0;
      sound_timer_q   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_start_address(12'h000);
      test_system_words();
      drain_results();
      write_start_address(12'hFFF);
      test_alu_flags();
      test_control_flow();
      drain_results();
      write_start_address(12'($urandom));
      test_timers_and_index();
      test_unsupported_words();
      test_index_wraparound();
      test_stack_wraparound();
      drain_results();
      write_start_address(START_ADDRESS_RESET);
      test_random_program();
      drain_results();
      repeat (10) @(posedge clock);

      if (fault_count == 0) begin
         $display("chip8_instruction_execute_core test passed");
      end else begin
         $display("chip8_instruction_execute_core test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hdl
hdl/c8x_pkg.sv
hdl/c8x_exec.sv
hdl/c8x_stack.sv
hdl/chip8_instruction_execute_core.sv
hdl/c8x_checker.sv
tb/testbench.sv
